@@ design/cache_block_transfer_plan_generator_defines.svh @@
// Shared assertion macros for the plan generator checker.
`ifndef CACHE_BLOCK_TRANSFER_PLAN_GENERATOR_DEFINES_SVH
`define CACHE_BLOCK_TRANSFER_PLAN_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CBTP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbtp assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CBTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbtp assertion failed");

`endif

@@ design/cbtp_pkg.sv @@
`default_nettype none
package cbtp_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_SHARD_COUNT    = 2'd0;
  localparam logic [1:0] REG_SHARD_RANK     = 2'd1;
  localparam logic [1:0] REG_HYBRID_MODE    = 2'd2;
  localparam logic [1:0] REG_VIRTUAL_LAYOUT = 2'd3;

  localparam logic KIND_FULL = 1'b0;
  localparam logic KIND_INCR = 1'b1;

  localparam logic [1:0] GRP_FULL   = 2'd0;
  localparam logic [1:0] GRP_LINEAR = 2'd1;
  localparam logic [1:0] GRP_WINDOW = 2'd2;
  localparam logic [1:0] GRP_OTHER  = 2'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_RANK  = 3'd1;
  localparam logic [2:0] ERR_RANGE = 3'd2;
  localparam logic [2:0] ERR_SHORT = 3'd3;
  localparam logic [2:0] ERR_GROUP = 3'd4;

  typedef struct packed {
    logic [3:0] shard_count;
    logic [2:0] shard_rank;
    logic       hybrid_mode;
    logic       virtual_layout;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] total_blocks;
    logic [6:0] start_block;
    logic [1:0] group_kind;
    logic [6:0] range_begin;
    logic [6:0] range_end;
    logic       terminal_chunk;
  } in_item_t;

  typedef struct packed {
    logic [5:0] logical_block;
    logic [5:0] cache_slot;
    logic       empty_plan;
    logic [2:0] error_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_en;
    logic done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/cbtp_regs.sv @@
`default_nettype none
module cbtp_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbtp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cbtp_pkg::DATA_W-1:0]   pwdata,
  output logic      [cbtp_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output cbtp_pkg::cfg_t                     cfg_o
);

  cbtp_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cbtp_pkg::REG_SHARD_COUNT:    cfg_d.shard_count    = pwdata[3:0];
        cbtp_pkg::REG_SHARD_RANK:     cfg_d.shard_rank     = pwdata[2:0];
        cbtp_pkg::REG_HYBRID_MODE:    cfg_d.hybrid_mode    = pwdata[0];
        cbtp_pkg::REG_VIRTUAL_LAYOUT: cfg_d.virtual_layout = pwdata[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cbtp_pkg::REG_SHARD_COUNT:    prdata = {28'd0, cfg_q.shard_count};
      cbtp_pkg::REG_SHARD_RANK:     prdata = {29'd0, cfg_q.shard_rank};
      cbtp_pkg::REG_HYBRID_MODE:    prdata = {31'd0, cfg_q.hybrid_mode};
      cbtp_pkg::REG_VIRTUAL_LAYOUT: prdata = {31'd0, cfg_q.virtual_layout};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shard_count    <= 4'd1;
      cfg_q.shard_rank     <= 3'd0;
      cfg_q.hybrid_mode    <= 1'b0;
      cfg_q.virtual_layout <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ design/cbtp_ctrl.sv @@
`default_nettype none
module cbtp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  cbtp_pkg::dp_status_t      status_i,
  output cbtp_pkg::dp_cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       stall;

  assign in_ready_o = (state_q == ST_IDLE);
  // a new pair needs the output register when one is already pending
  assign stall = status_i.hit && status_i.pend_valid && !status_i.out_free;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.check  = (state_q == ST_CHECK);
    cmd_o.step   = (state_q == ST_WALK) && !status_i.done && !stall;
    cmd_o.finish = (state_q == ST_FINISH) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.walk_en ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        if (status_i.done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ design/cbtp_dp.sv @@
`default_nettype none
module cbtp_dp #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned MAX_SHARDS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  cbtp_pkg::cfg_t            cfg_i,
  input  cbtp_pkg::in_item_t        in_data_i,
  input  cbtp_pkg::dp_cmd_t         cmd_i,
  output cbtp_pkg::dp_status_t      status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output cbtp_pkg::out_item_t       out_data_o
);

  localparam logic [6:0] BlockLim = 7'(MAX_BLOCKS);
  localparam logic [6:0] ShardLim = 7'(MAX_SHARDS);

  cbtp_pkg::in_item_t  req_q, in_sat;
  logic [2:0]          err_q, chk_err;
  logic                virt_q, hyb_q, shard_q, filt_q, lin_q;
  logic [6:0]          start_q;
  logic [6:0]          p_q;
  logic [3:0]          rem_q;
  logic [6:0]          quo_q;
  logic [7:0]          base_q;
  logic                pend_valid_q;
  logic [5:0]          pend_key_q, pend_slot_q;
  logic                out_valid_q;
  cbtp_pkg::out_item_t out_q;

  // setup decode
  logic       lw, bad_shard, range_bad, build_go, chk_walk, hyb_eff;
  logic       chk_virt, chk_shard, chk_filt;
  logic [6:0] tot, start_nv, chk_start;
  logic [3:0] cnt;

  // walk
  logic [7:0] cnt8, tot8, base_c1, base_c2, key8;
  logic       done, tail_ok, hit_v, hit_nv, hit, out_free;
  logic [5:0] cur_key, cur_slot, key_v;
  logic [3:0] rem_inc;

  always_comb begin
    in_sat = in_data_i;
    if (in_data_i.total_blocks > BlockLim) in_sat.total_blocks = BlockLim;
  end

  assign cnt = cfg_i.shard_count;
  assign tot = req_q.total_blocks;
  assign lw  = (req_q.group_kind == cbtp_pkg::GRP_LINEAR) ||
               (req_q.group_kind == cbtp_pkg::GRP_WINDOW);
  assign bad_shard = (cnt == 4'd0) || ({3'd0, cnt} > ShardLim) ||
                     ({1'b0, cfg_i.shard_rank} >= cnt);
  assign range_bad = (req_q.range_begin > req_q.range_end) || (req_q.range_end > tot);
  assign build_go  = (tot != 7'd0) && !bad_shard;

  always_comb begin
    chk_err  = cbtp_pkg::ERR_NONE;
    chk_walk = 1'b0;
    hyb_eff  = cfg_i.hybrid_mode;
    if (req_q.kind == cbtp_pkg::KIND_FULL) begin
      chk_err  = (tot != 7'd0 && bad_shard) ? cbtp_pkg::ERR_RANK : cbtp_pkg::ERR_NONE;
      chk_walk = build_go;
    end else if (range_bad) begin
      chk_err = cbtp_pkg::ERR_RANGE;
    end else if (lw) begin
      hyb_eff = 1'b1;
      if (req_q.terminal_chunk) begin
        if (req_q.range_end != tot) begin
          chk_err = cbtp_pkg::ERR_SHORT;
        end else begin
          chk_err  = (tot != 7'd0 && bad_shard) ? cbtp_pkg::ERR_RANK : cbtp_pkg::ERR_NONE;
          chk_walk = build_go;
        end
      end
    end else if (req_q.group_kind == cbtp_pkg::GRP_OTHER) begin
      chk_err = cbtp_pkg::ERR_GROUP;
    end else begin
      chk_err  = (tot != 7'd0 && bad_shard) ? cbtp_pkg::ERR_RANK : cbtp_pkg::ERR_NONE;
      chk_walk = build_go;
    end
  end

  assign chk_virt  = (cnt > 4'd1) && cfg_i.virtual_layout && lw;
  assign chk_shard = (cnt > 4'd1) && (req_q.group_kind == cbtp_pkg::GRP_FULL);
  assign chk_filt  = (req_q.kind == cbtp_pkg::KIND_INCR) &&
                     (req_q.group_kind == cbtp_pkg::GRP_FULL);

  always_comb begin
    if (hyb_eff && req_q.group_kind == cbtp_pkg::GRP_LINEAR) begin
      start_nv = 7'(tot - 7'd1);
    end else if (hyb_eff && req_q.group_kind == cbtp_pkg::GRP_WINDOW) begin
      start_nv = (tot > 7'd2) ? 7'(tot - 7'd2) : 7'd0;
    end else begin
      start_nv = (req_q.start_block < tot) ? req_q.start_block : tot;
    end
    if (chk_virt) begin
      chk_start = hyb_eff ? 7'd0 : req_q.start_block;
    end else begin
      chk_start = start_nv;
    end
  end

  // walk over positions; compact layout tracks p*count in base_q
  assign cnt8    = {4'd0, cnt};
  assign tot8    = {1'b0, tot};
  assign base_c1 = 8'(base_q + cnt8);
  assign base_c2 = 8'(base_c1 + cnt8);
  assign key8    = 8'(base_c1 - 8'd1);
  assign key_v   = (key8 > 8'(tot8 - 8'd1)) ? 6'(tot - 7'd1) : key8[5:0];
  assign done    = virt_q ? (base_q >= tot8) : (p_q >= tot);
  assign tail_ok = !hyb_q || (lin_q ? (base_c1 >= tot8) : (base_c2 >= tot8));
  assign hit_v   = (p_q >= start_q) && tail_ok;
  assign hit_nv  = (p_q >= start_q) &&
                   (!shard_q || (rem_q == {1'b0, cfg_i.shard_rank})) &&
                   (!filt_q || ((p_q >= req_q.range_begin) && (p_q < req_q.range_end)));
  assign hit     = !done && (virt_q ? hit_v : hit_nv);
  assign cur_key  = virt_q ? key_v : p_q[5:0];
  assign cur_slot = (shard_q && !virt_q) ? quo_q[5:0] : p_q[5:0];
  assign rem_inc  = 4'(rem_q + 4'd1);
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.walk_en    = chk_walk;
  assign status_o.done       = done;
  assign status_o.hit        = hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_sat;
    if (cmd_i.check) begin
      err_q   <= chk_err;
      virt_q  <= chk_virt;
      hyb_q   <= hyb_eff;
      shard_q <= chk_shard;
      filt_q  <= chk_filt;
      lin_q   <= (req_q.group_kind == cbtp_pkg::GRP_LINEAR);
      start_q <= chk_start;
      p_q     <= 7'd0;
      rem_q   <= 4'd0;
      quo_q   <= 7'd0;
      base_q  <= 8'd0;
    end else if (cmd_i.step) begin
      p_q    <= 7'(p_q + 7'd1);
      base_q <= base_c1;
      if (rem_inc == cnt) begin
        rem_q <= 4'd0;
        quo_q <= 7'(quo_q + 7'd1);
      end else begin
        rem_q <= rem_inc;
      end
      if (hit) begin
        pend_key_q  <= cur_key;
        pend_slot_q <= cur_slot;
      end
    end
    if (cmd_i.step && hit && pend_valid_q) begin
      out_q.logical_block <= pend_key_q;
      out_q.cache_slot    <= pend_slot_q;
      out_q.empty_plan    <= 1'b0;
      out_q.error_code    <= cbtp_pkg::ERR_NONE;
      out_q.last          <= 1'b0;
    end else if (cmd_i.finish) begin
      out_q.last       <= 1'b1;
      out_q.error_code <= err_q;
      if (err_q != cbtp_pkg::ERR_NONE) begin
        out_q.logical_block <= 6'd0;
        out_q.cache_slot    <= 6'd0;
        out_q.empty_plan    <= 1'b0;
      end else if (pend_valid_q) begin
        out_q.logical_block <= pend_key_q;
        out_q.cache_slot    <= pend_slot_q;
        out_q.empty_plan    <= 1'b0;
      end else begin
        out_q.logical_block <= 6'd0;
        out_q.cache_slot    <= 6'd0;
        out_q.empty_plan    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.step && hit) begin
        pend_valid_q <= 1'b1;
      end
      if ((cmd_i.step && hit && pend_valid_q) || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/cache_block_transfer_plan_generator.sv @@
// A request passes the accept, check, walk and finish steps of the controller in that order.
// The walk covers total_blocks positions, or ceil(total/shard_count) in compact layout.
// A new request is taken only once the last one has finished; each hit position gives one pair;
// errors, zero-block requests and non-terminal linear or window chunks skip the walk.
// The position walk sets the pace; output back-pressure stalls the walk and the finish step.
// Reset (rst_ni low, async) idles the controller, empties the output, shard_count to 1.
`default_nettype none
module cache_block_transfer_plan_generator #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned MAX_SHARDS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  cbtp_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output cbtp_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbtp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [cbtp_pkg::DATA_W-1:0]   pwdata,
  output logic      [cbtp_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  cbtp_pkg::cfg_t       cfg;
  cbtp_pkg::dp_cmd_t    cmd;
  cbtp_pkg::dp_status_t status;

  cbtp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cbtp_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_SHARDS (MAX_SHARDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ design/cbtp_checker.sv @@
`default_nettype none
`include "cache_block_transfer_plan_generator_defines.svh"
module cbtp_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input cbtp_pkg::out_item_t out_data_o
);

  logic empty_seen, empty_shape, error_seen, error_shape;

  assign empty_seen  = out_valid_o && out_data_o.empty_plan;
  assign empty_shape = out_data_o.last &&
                       (out_data_o.error_code == cbtp_pkg::ERR_NONE) &&
                       (out_data_o.logical_block == 6'd0) &&
                       (out_data_o.cache_slot == 6'd0);
  assign error_seen  = out_valid_o && (out_data_o.error_code != cbtp_pkg::ERR_NONE);
  assign error_shape = out_data_o.last && !out_data_o.empty_plan;

  `CBTP_ASSERT_NEXT(out_hold_a, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `CBTP_ASSERT_NEXT(busy_after_req_a, in_valid_i && in_ready_o, !in_ready_o)
  `CBTP_ASSERT_SAME(empty_form_a, empty_seen, empty_shape)
  `CBTP_ASSERT_SAME(error_form_a, error_seen, error_shape)

endmodule

bind cache_block_transfer_plan_generator cbtp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

@@ sim/tb.sv @@
module tb;

  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned MAX_SHARDS = 8;

  class transfer_plan_checker;
    logic [3:0]          shard_count;
    logic [2:0]          shard_rank;
    bit                  hybrid;
    bit                  compact;
    cbtp_pkg::out_item_t expected[$];
    int unsigned         keys[$];
    int unsigned         slots[$];
    int                  mismatches;

    function new();
      shard_count = 4'd1;
      shard_rank  = 3'd0;
      hybrid      = 1'b0;
      compact     = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        cbtp_pkg::REG_SHARD_COUNT:    shard_count = value[3:0];
        cbtp_pkg::REG_SHARD_RANK:     shard_rank  = value[2:0];
        cbtp_pkg::REG_HYBRID_MODE:    hybrid      = value[0];
        cbtp_pkg::REG_VIRTUAL_LAYOUT: compact     = value[0];
        default: ;
      endcase
    endfunction

    function logic [2:0] build_pairs(int unsigned total, int unsigned ff, bit hy,
                                     logic [1:0] grp);
      int unsigned c;
      int unsigned canon;
      int unsigned tail;
      int unsigned start;
      int unsigned key;
      keys.delete();
      slots.delete();
      c = shard_count;
      if (total == 0) return cbtp_pkg::ERR_NONE;
      if (c < 1 || c > MAX_SHARDS || shard_rank >= c) return cbtp_pkg::ERR_RANK;
      if (c > 1 && compact && (grp == cbtp_pkg::GRP_LINEAR || grp == cbtp_pkg::GRP_WINDOW)) begin
        canon = (total + c - 1) / c;
        tail = (grp == cbtp_pkg::GRP_LINEAR) ? 1 : 2;
        if (hy) start = (canon > tail) ? canon - tail : 0;
        else start = (ff < canon) ? ff : canon;
        for (int unsigned p = start; p < canon && keys.size() < MAX_BLOCKS; p++) begin
          key = (p + 1) * c - 1;
          if (key > total - 1) key = total - 1;
          keys  = {keys, key};
          slots = {slots, p};
        end
        return cbtp_pkg::ERR_NONE;
      end
      if (hy && grp == cbtp_pkg::GRP_LINEAR) start = total - 1;
      else if (hy && grp == cbtp_pkg::GRP_WINDOW) start = (total > 2) ? total - 2 : 0;
      else start = (ff < total) ? ff : total;
      for (int unsigned p = start; p < total && keys.size() < MAX_BLOCKS; p++) begin
        if (c > 1 && grp == cbtp_pkg::GRP_FULL) begin
          if (p % c == shard_rank) begin
            keys  = {keys, p};
            slots = {slots, p / c};
          end
        end else begin
          keys  = {keys, p};
          slots = {slots, p};
        end
      end
      return cbtp_pkg::ERR_NONE;
    endfunction

    function void note_request(cbtp_pkg::in_item_t req);
      int unsigned         tot;
      int unsigned         fk[$];
      int unsigned         fs[$];
      logic [2:0]          err;
      cbtp_pkg::out_item_t item;
      tot = (req.total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : req.total_blocks;
      err = cbtp_pkg::ERR_NONE;
      keys.delete();
      slots.delete();
      if (req.kind == cbtp_pkg::KIND_FULL) begin
        err = build_pairs(tot, req.start_block, hybrid, req.group_kind);
      end else if (req.range_begin > req.range_end || req.range_end > tot) begin
        err = cbtp_pkg::ERR_RANGE;
      end else if (req.group_kind == cbtp_pkg::GRP_LINEAR ||
                   req.group_kind == cbtp_pkg::GRP_WINDOW) begin
        if (req.terminal_chunk) begin
          if (req.range_end != tot) err = cbtp_pkg::ERR_SHORT;
          else err = build_pairs(tot, req.start_block, 1'b1, req.group_kind);
        end
      end else if (req.group_kind != cbtp_pkg::GRP_FULL) begin
        err = cbtp_pkg::ERR_GROUP;
      end else begin
        err = build_pairs(tot, req.start_block, hybrid, req.group_kind);
        if (err == cbtp_pkg::ERR_NONE) begin
          foreach (keys[i]) begin
            if (keys[i] >= req.range_begin && keys[i] < req.range_end) begin
              fk = {fk, keys[i]};
              fs = {fs, slots[i]};
            end
          end
          keys = fk;
          slots = fs;
        end
      end
      if (err != cbtp_pkg::ERR_NONE || keys.size() == 0) begin
        item.logical_block = 6'd0;
        item.cache_slot    = 6'd0;
        item.empty_plan    = (err == cbtp_pkg::ERR_NONE);
        item.error_code    = err;
        item.last          = 1'b1;
        expected = {expected, item};
      end else begin
        foreach (keys[i]) begin
          item.logical_block = keys[i][5:0];
          item.cache_slot    = slots[i][5:0];
          item.empty_plan    = 1'b0;
          item.error_code    = cbtp_pkg::ERR_NONE;
          item.last          = (i == keys.size() - 1);
          expected = {expected, item};
        end
      end
    endfunction

    function void check_result(cbtp_pkg::out_item_t got);
      cbtp_pkg::out_item_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: unexpected transfer lb=%0d slot=%0d empty=%0d err=%0d last=%0d",
                   $time, got.logical_block, got.cache_slot, got.empty_plan,
                   got.error_code, got.last);
        return;
      end
      want = expected.pop_front();
      if (got.logical_block !== want.logical_block || got.cache_slot !== want.cache_slot ||
          got.empty_plan !== want.empty_plan || got.error_code !== want.error_code ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                   $time, want.logical_block, want.cache_slot, want.empty_plan,
                   want.error_code, want.last, got.logical_block, got.cache_slot,
                   got.empty_plan, got.error_code, got.last);
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_ready_o;
  cbtp_pkg::in_item_t              in_data;
  logic                            out_valid_o;
  logic                            out_ready;
  cbtp_pkg::out_item_t             out_data_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [cbtp_pkg::ADDR_W-1:0]     paddr;
  logic [cbtp_pkg::DATA_W-1:0]     pwdata;
  logic [cbtp_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  transfer_plan_checker plans = new();

  cache_block_transfer_plan_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) plans.note_request(in_data);
    if (rst_ni && out_valid_o && out_ready) plans.check_result(out_data_o);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        out_ready <= !(rx_gaps && $urandom_range(99) < 23);
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    plans.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_shards(int unsigned cnt, int unsigned rank, bit hyb, bit virt);
    apb_write(cbtp_pkg::REG_SHARD_COUNT, cnt);
    apb_write(cbtp_pkg::REG_SHARD_RANK, rank);
    apb_write(cbtp_pkg::REG_HYBRID_MODE, {31'd0, hyb});
    apb_write(cbtp_pkg::REG_VIRTUAL_LAYOUT, {31'd0, virt});
  endtask

  task automatic send_request(cbtp_pkg::in_item_t req);
    @(negedge clk_i);
    while (tx_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle(int unsigned tail);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (plans.expected.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic cbtp_pkg::in_item_t make_req(logic kind, int unsigned total,
                                                  int unsigned ff, logic [1:0] grp,
                                                  int unsigned rb, int unsigned re,
                                                  logic term);
    cbtp_pkg::in_item_t r;
    r.kind           = kind;
    r.total_blocks   = total[6:0];
    r.start_block    = ff[6:0];
    r.group_kind     = grp;
    r.range_begin    = rb[6:0];
    r.range_end      = re[6:0];
    r.terminal_chunk = term;
    return r;
  endfunction

  function automatic cbtp_pkg::in_item_t random_request();
    cbtp_pkg::in_item_t r;
    int unsigned        sel;
    int unsigned        total;
    int unsigned        eff;
    int unsigned        rb;
    int unsigned        re;
    sel = $urandom_range(99);
    if (sel < 70) total = $urandom_range(16);
    else if (sel < 92) total = $urandom_range(64);
    else total = $urandom_range(127);
    eff = (total > MAX_BLOCKS) ? MAX_BLOCKS : total;
    r.kind           = 1'($urandom_range(1));
    r.total_blocks   = total[6:0];
    r.start_block    = ($urandom_range(99) < 80) ? 7'($urandom_range(eff)) :
                                                   7'($urandom_range(127));
    r.group_kind     = 2'($urandom_range(3));
    r.terminal_chunk = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      re = (r.terminal_chunk && $urandom_range(99) < 70) ? eff : $urandom_range(eff);
      rb = $urandom_range(re);
    end else begin
      re = $urandom_range(127);
      rb = $urandom_range(127);
    end
    r.range_begin = rb[6:0];
    r.range_end   = re[6:0];
    return r;
  endfunction

  initial begin
    int unsigned cnt;
    int unsigned rank;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: one shard, no hybrid, plain layout
    send_request(make_req(cbtp_pkg::KIND_FULL, 0, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 64, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 127, 127, cbtp_pkg::GRP_LINEAR, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 5, 2, cbtp_pkg::GRP_OTHER, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_FULL, 5, 3, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_FULL, 0, 11, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_LINEAR, 0, 9, 1'b1));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_WINDOW, 0, 5, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_WINDOW, 4, 10, 1'b1));
    send_request(make_req(cbtp_pkg::KIND_INCR, 10, 0, cbtp_pkg::GRP_OTHER, 2, 6, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 20, 0, cbtp_pkg::GRP_FULL, 4, 12, 1'b0));
    wait_idle(8);

    set_shards(4, 3, 1'b1, 1'b1);
    send_request(make_req(cbtp_pkg::KIND_FULL, 10, 0, cbtp_pkg::GRP_LINEAR, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 64, 0, cbtp_pkg::GRP_WINDOW, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 13, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 13, 0, cbtp_pkg::GRP_FULL, 4, 12, 1'b0));
    wait_idle(8);

    set_shards(8, 7, 1'b0, 1'b1);
    send_request(make_req(cbtp_pkg::KIND_FULL, 64, 3, cbtp_pkg::GRP_WINDOW, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 127, 0, cbtp_pkg::GRP_LINEAR, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 64, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    wait_idle(8);

    // broken shard setups
    set_shards(0, 0, 1'b0, 1'b0);
    send_request(make_req(cbtp_pkg::KIND_FULL, 5, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_FULL, 0, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    wait_idle(8);
    set_shards(2, 5, 1'b0, 1'b0);
    send_request(make_req(cbtp_pkg::KIND_FULL, 7, 0, cbtp_pkg::GRP_FULL, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 7, 0, cbtp_pkg::GRP_FULL, 6, 2, 1'b0));
    wait_idle(8);
    set_shards(15, 0, 1'b1, 1'b1);
    send_request(make_req(cbtp_pkg::KIND_FULL, 9, 0, cbtp_pkg::GRP_WINDOW, 0, 0, 1'b0));
    send_request(make_req(cbtp_pkg::KIND_INCR, 9, 0, cbtp_pkg::GRP_LINEAR, 0, 9, 1'b1));
    wait_idle(8);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        cnt  = 8;
        rank = 0;
      end else if (ph == 1) begin
        cnt  = 1;
        rank = 0;
      end else begin
        if ($urandom_range(99) < 85) cnt = $urandom_range(MAX_SHARDS, 1);
        else cnt = $urandom_range(1) ? 0 : $urandom_range(15, 9);
        if ($urandom_range(99) < 85 && cnt >= 1 && cnt <= MAX_SHARDS)
          rank = $urandom_range(cnt - 1);
        else rank = $urandom_range(7);
      end
      set_shards(cnt, rank, 1'($urandom_range(1)), 1'($urandom_range(1)));
      tx_gaps = (ph != 2);
      rx_gaps = (ph != 2);
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < 26; n++) send_request(random_request());
      wait_idle(8);
    end

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_idle(70);
    if (plans.mismatches == 0 && plans.expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ cache_block_transfer_plan_generator.f @@
+incdir+design
design/cbtp_pkg.sv
design/cbtp_regs.sv
design/cbtp_ctrl.sv
design/cbtp_dp.sv
design/cache_block_transfer_plan_generator.sv
design/cbtp_checker.sv
sim/tb.sv
